// ----- rtl/core/lfu_pkg.sv -----
// lfu_pkg: shared types and constants for the lfu cache table
// no dependencies; imported by every module of the block except lfu_ram
`default_nettype none
package lfu_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned USES_W  = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned ENT_W   = KEY_W + VAL_W + USES_W + STAMP_W;

  // apb register map
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 2'd0;
  localparam logic [CAP_W-1:0]   CAP_RESET     = 5'd16;

  // operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_OUT
  } lfu_state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } lfu_cmd_t;

  typedef struct packed {
    logic cap_zero;
    logic scan_last;
  } lfu_stat_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [USES_W-1:0]  uses;
    logic [STAMP_W-1:0] stamp;
  } lfu_entry_t;

endpackage
`default_nettype wire

// ----- rtl/core/lfu_if.sv -----
// lfu_in_if / lfu_out_if: valid-ready channels for request and result items
// depends on lfu_pkg for field widths
`default_nettype none
interface lfu_in_if;
  import lfu_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [KEY_W-1:0] lookup_key;
  logic [VAL_W-1:0] write_value;
  modport source (output valid, operation, lookup_key, write_value, input ready);
  modport sink   (input valid, operation, lookup_key, write_value, output ready);
endinterface

interface lfu_out_if;
  import lfu_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] read_value;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;
  modport source (output valid, found, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, found, read_value, evicted, evicted_key, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lfu_ram.sv -----
// lfu_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module lfu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/core/lfu_ctrl.sv -----
// lfu_ctrl: sequencer for one item: accept, scan, commit, deliver (capacity 0 goes straight to deliver)
// depends on lfu_pkg
`default_nettype none
module lfu_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire lfu_pkg::lfu_stat_t stat_i,
  output lfu_pkg::lfu_cmd_t       cmd_o
);
  import lfu_pkg::*;

  lfu_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = stat_i.cap_zero ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/core/lfu_dpath.sv -----
// lfu_dpath: entry store, scan for hit and replacement victim, write-back
// depends on lfu_pkg and lfu_ram
`default_nettype none
module lfu_dpath #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lfu_pkg::lfu_cmd_t            cmd_i,
  output lfu_pkg::lfu_stat_t                stat_o,
  input  wire logic [lfu_pkg::CAP_W-1:0]   capacity_i,
  input  wire logic                        operation_i,
  input  wire logic [lfu_pkg::KEY_W-1:0]   lookup_key_i,
  input  wire logic [lfu_pkg::VAL_W-1:0]   write_value_i,
  output logic                             found_o,
  output logic      [lfu_pkg::VAL_W-1:0]   read_value_o,
  output logic                             evicted_o,
  output logic      [lfu_pkg::KEY_W-1:0]   evicted_key_o
);
  import lfu_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned IW = $clog2(ENTRIES + 1);

  // request and control registers
  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [IW-1:0]     occ_q;
  logic [IW-1:0]     idx_q;
  logic [ENTRIES-1:0] valid_q;

  // scan results
  logic              hit_q, min_found_q, free_found_q;
  logic [AW-1:0]     hit_slot_q, min_slot_q, free_slot_q;
  logic [VAL_W-1:0]  hit_val_q;
  logic [USES_W-1:0] hit_uses_q, min_uses_q;
  logic [STAMP_W-1:0] min_stamp_q;
  logic [KEY_W-1:0]  min_key_q;

  lfu_entry_t        rd_ent, wr_ent;
  logic              we;
  logic [AW-1:0]     waddr, raddr, eslot;
  logic [IW-1:0]     idx_m1;
  logic              eval;
  logic [31:0]       cap_ext, cap_eff, occ_ext;
  logic              full;

  // entry store
  lfu_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_ent),
    .raddr_i (raddr),
    .rdata_o (rd_ent)
  );

  // scan addressing: read slot idx, evaluate slot idx-1
  assign idx_m1 = idx_q - IW'(1);
  assign eslot  = idx_m1[AW-1:0];
  assign raddr  = idx_q[AW-1:0];
  assign eval   = cmd_i.scan && (idx_q != '0);

  assign stat_o.cap_zero  = (capacity_i == '0);
  assign stat_o.scan_last = (idx_q == IW'(ENTRIES));

  // effective capacity and fullness
  assign cap_ext = 32'(capacity_i);
  assign cap_eff = (cap_ext > 32'(ENTRIES)) ? 32'(ENTRIES) : cap_ext;
  assign occ_ext = 32'(occ_q);
  assign full    = occ_ext >= cap_eff;

  // write-back entry selection
  always_comb begin
    we     = 1'b0;
    waddr  = hit_slot_q;
    wr_ent.key   = key_q;
    wr_ent.value = val_q;
    wr_ent.uses  = USES_W'(1);
    wr_ent.stamp = stamp_q;
    if (cmd_i.commit) begin
      if (hit_q) begin
        we = 1'b1;
        wr_ent.value = (op_q == OP_PUT) ? val_q : hit_val_q;
        wr_ent.uses  = (hit_uses_q == '1) ? hit_uses_q : hit_uses_q + USES_W'(1);
      end else if (op_q == OP_PUT) begin
        we    = 1'b1;
        waddr = full ? min_slot_q : free_slot_q;
      end
    end
  end

  // control state: valid bits, occupancy, stamp, scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      occ_q        <= '0;
      stamp_q      <= '0;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      min_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        idx_q        <= '0;
        hit_q        <= 1'b0;
        min_found_q  <= 1'b0;
        free_found_q <= 1'b0;
        if (capacity_i != '0 && stamp_q != '1) begin
          stamp_q <= stamp_q + STAMP_W'(1);
        end
      end
      if (cmd_i.scan) begin
        idx_q <= idx_q + IW'(1);
      end
      if (eval) begin
        if (!hit_q && valid_q[eslot] && rd_ent.key == key_q) begin
          hit_q <= 1'b1;
        end
        if (valid_q[eslot] && (!min_found_q || rd_ent.uses < min_uses_q ||
            (rd_ent.uses == min_uses_q && rd_ent.stamp < min_stamp_q))) begin
          min_found_q <= 1'b1;
        end
        if (!valid_q[eslot]) begin
          free_found_q <= 1'b1;
        end
      end
      if (cmd_i.commit && !hit_q && op_q == OP_PUT) begin
        valid_q[waddr] <= 1'b1;
        if (!full) begin
          occ_q <= occ_q + IW'(1);
        end
      end
    end
  end

  // payload registers: request, scan captures, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q          <= operation_i;
      key_q         <= lookup_key_i;
      val_q         <= write_value_i;
      found_o       <= 1'b0;
      read_value_o  <= '0;
      evicted_o     <= 1'b0;
      evicted_key_o <= '0;
    end
    if (eval) begin
      if (!hit_q && valid_q[eslot] && rd_ent.key == key_q) begin
        hit_slot_q <= eslot;
        hit_val_q  <= rd_ent.value;
        hit_uses_q <= rd_ent.uses;
      end
      if (valid_q[eslot] && (!min_found_q || rd_ent.uses < min_uses_q ||
          (rd_ent.uses == min_uses_q && rd_ent.stamp < min_stamp_q))) begin
        min_slot_q  <= eslot;
        min_uses_q  <= rd_ent.uses;
        min_stamp_q <= rd_ent.stamp;
        min_key_q   <= rd_ent.key;
      end
      if (!valid_q[eslot] && !free_found_q) begin
        free_slot_q <= eslot;
      end
    end
    if (cmd_i.commit) begin
      if (hit_q) begin
        found_o      <= 1'b1;
        read_value_o <= (op_q == OP_GET) ? hit_val_q : '0;
      end else if (op_q == OP_PUT && full) begin
        evicted_o     <= 1'b1;
        evicted_key_o <= min_key_q;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/lfu_cache_table_top.sv -----
// lfu_cache_table_top: lfu cache top level with apb capacity register
// depends on lfu_pkg, lfu_if, lfu_ctrl, lfu_dpath, lfu_ram
`default_nettype none
// Key-value cache with least-frequently-used replacement, oldest stamp and
// then lowest slot breaking ties. One item is handled at a time: after
// acceptance the scan reads the entry ram one slot per cycle, then the
// result is committed and held until it is taken. With capacity 0 an item
// returns all-zero fields in the cycle after it is accepted, with no scan.
// The capacity register sits at apb address 0.
module lfu_cache_table_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  lfu_in_if.sink                             in_i,
  lfu_out_if.source                          out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lfu_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [lfu_pkg::PDATA_W-1:0]   pwdata,
  output logic      [lfu_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import lfu_pkg::*;

  logic [CAP_W-1:0] cap_q;
  lfu_cmd_t         cmd;
  lfu_stat_t        stat;

  // capacity register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_CAPACITY) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end
  assign prdata = (paddr == ADDR_CAPACITY) ? PDATA_W'(cap_q) : '0;

  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lfu_dpath #(.ENTRIES(ENTRIES)) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .capacity_i    (cap_q),
    .operation_i   (in_i.operation),
    .lookup_key_i  (in_i.lookup_key),
    .write_value_i (in_i.write_value),
    .found_o       (out_o.found),
    .read_value_o  (out_o.read_value),
    .evicted_o     (out_o.evicted),
    .evicted_key_o (out_o.evicted_key)
  );
endmodule
`default_nettype wire
